// ===== rtl/heart_rate_peak_detector_top_macros.svh =====
// ============================================================================
// Assertion macros for the heart rate peak detector
// Implication checks, compiled out for synthesis.
// ============================================================================
`ifndef HEART_RATE_PEAK_DETECTOR_TOP_MACROS_SVH
`define HEART_RATE_PEAK_DETECTOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: when a holds, b holds.
`define HRPD_ASSERT_IMPL(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
        else $error("hrpd assertion failed");

// Next-cycle implication: when a holds, b holds in the next cycle.
`define HRPD_ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
        else $error("hrpd assertion failed");

`else

`define HRPD_ASSERT_IMPL(label, clk, rstn, a, b)
`define HRPD_ASSERT_NEXT(label, clk, rstn, a, b)

`endif

`endif

// ===== rtl/hrpd_pkg.sv =====
// ============================================================================
// hrpd_pkg
// Widths, constants and types shared by the heart rate peak detector.
// ============================================================================
package hrpd_pkg;

    // Datapath sizing
    localparam int SAMPLE_WIDTH = 24;
    localparam int COUNT_WIDTH  = 32;
    localparam int MIN_THR_W    = 23;
    localparam int RATE_W       = 16;
    localparam int RATE_OUT_W   = 23;

    // Threshold holds the floor or a peak (non-negative sample)
    localparam int PEAK_W = SAMPLE_WIDTH - 1;
    localparam int THR_W  = (MIN_THR_W > PEAK_W) ? MIN_THR_W : PEAK_W;
    localparam int CMP_W  = THR_W + 2;

    // Divider: 60*rate<<10 fits in 32 bits for a 16-bit rate
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    // Stream widths, whole bytes
    localparam int S_TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W = ((1 + RATE_OUT_W + 7) / 8) * 8;

    // Constants
    localparam int THR_RESET       = 100;
    localparam int RATE_RESET      = 1000;
    localparam int DECAY_MUL       = 511;
    localparam int DECAY_SHIFT     = 9;
    localparam int SECONDS_PER_MIN = 60;
    localparam int RATE_FRAC_BITS  = 10;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE   = 2'd1;
    localparam int CFG_DATA_W = MIN_THR_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_OUT
    } hrpd_state_t;

endpackage

// ===== rtl/heart_rate_peak_detector_top.sv =====
// Steps: a sample without a beat passes through ST_EVAL and ST_OUT; a sample
//   that completes a beat also runs ST_DIV (32-step bit-serial divide for the rate).
// Flow: the block takes a new sample only after the last one has left ST_OUT;
//   s_tready is high only when idle, and ST_OUT waits while the result is held.
// Reset: synchronous, active-low aresetn; threshold 100, rate 1000, counters
//   and peak cleared, result channel empty. No clearing pass.
// ============================================================================
// heart_rate_peak_detector_top
// Adaptive-threshold R-peak detector reporting heart rate in BPM * 1024.
// ============================================================================
`include "heart_rate_peak_detector_top_macros.svh"

module heart_rate_peak_detector_top (
    input  logic                                aclk,
    input  logic                                aresetn,

    // Sample stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [hrpd_pkg::S_TDATA_W-1:0]      s_tdata,   // [23:0] sample

    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [hrpd_pkg::M_TDATA_W-1:0]      m_tdata,   // [0] above_threshold,
                                                           // [23:1] rate_q10
    output logic [0:0]                          m_tuser,   // [0] beat_valid

    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hrpd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hrpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    hrpd_pkg::hrpd_state_t                      state_reg, state_next;

    // Configuration
    logic [hrpd_pkg::MIN_THR_W-1:0]             min_thr_reg;
    logic [hrpd_pkg::RATE_W-1:0]                rate_reg;

    // Detector state
    logic [hrpd_pkg::THR_W-1:0]                 thr_reg, thr_next;
    logic [hrpd_pkg::PEAK_W-1:0]                peak_reg, peak_next;
    logic [hrpd_pkg::COUNT_WIDTH-1:0]           peak_idx_reg, peak_idx_next;
    logic [hrpd_pkg::COUNT_WIDTH-1:0]           count_reg, count_next;
    logic signed [hrpd_pkg::SAMPLE_WIDTH-1:0]   prev_reg;

    // Item in flight
    logic signed [hrpd_pkg::SAMPLE_WIDTH-1:0]   sample_reg;
    logic                                       above_flag_reg, above_flag_next;
    logic                                       beat_flag_reg, beat_flag_next;

    // Output register
    logic                                       m_valid_reg, m_valid_next;
    logic                                       out_above_reg;
    logic                                       out_beat_reg;
    logic [hrpd_pkg::RATE_OUT_W-1:0]            out_rate_reg;

    // ------------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------------
    logic s_xfer;
    logic cfg_xfer;
    logic out_load;
    logic div_start;
    logic div_done;

    assign s_tready  = (state_reg == hrpd_pkg::ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    // ------------------------------------------------------------------------
    // Evaluation of the latched sample (used in ST_EVAL)
    // ------------------------------------------------------------------------
    logic signed [hrpd_pkg::CMP_W-1:0]          s_ext, prev_ext, thr_ext, peak_ext;
    logic                                       above, prev_above, peak_up;
    logic                                       interval_ok;
    logic [hrpd_pkg::COUNT_WIDTH-1:0]           count_inc;
    logic [hrpd_pkg::THR_W:0]                   thr_sum;
    logic [hrpd_pkg::THR_W+hrpd_pkg::DECAY_SHIFT-1:0] decay_prod;
    logic [hrpd_pkg::DIV_W-1:0]                 bpm_num, div_num, div_den, div_quot;

    always_comb begin
        s_ext    = hrpd_pkg::CMP_W'(sample_reg);
        prev_ext = hrpd_pkg::CMP_W'(prev_reg);
        thr_ext  = hrpd_pkg::CMP_W'(thr_reg);
        peak_ext = hrpd_pkg::CMP_W'(peak_reg);

        above      = s_ext > thr_ext;
        prev_above = prev_ext > thr_ext;
        peak_up    = s_ext > peak_ext;

        // Minimum beat interval: a quarter second of samples
        interval_ok = peak_idx_reg >
                      hrpd_pkg::COUNT_WIDTH'(rate_reg[hrpd_pkg::RATE_W-1:2]);

        count_inc  = count_reg + 1'b1;
        thr_sum    = {1'b0, thr_reg} + (hrpd_pkg::THR_W+1)'(peak_reg);
        decay_prod = (hrpd_pkg::THR_W+hrpd_pkg::DECAY_SHIFT)'(thr_reg) *
                     (hrpd_pkg::THR_W+hrpd_pkg::DECAY_SHIFT)'(hrpd_pkg::DECAY_MUL);

        // 60 * rate << 10
        bpm_num = hrpd_pkg::DIV_W'(rate_reg) * hrpd_pkg::DIV_W'(hrpd_pkg::SECONDS_PER_MIN);
        div_num = bpm_num << hrpd_pkg::RATE_FRAC_BITS;
        div_den = hrpd_pkg::DIV_W'(peak_idx_reg);
    end

    always_comb begin
        thr_next        = thr_reg;
        peak_next       = peak_reg;
        peak_idx_next   = peak_idx_reg;
        count_next      = count_reg;
        above_flag_next = above_flag_reg;
        beat_flag_next  = beat_flag_reg;

        if (state_reg == hrpd_pkg::ST_EVAL) begin
            above_flag_next = above;
            beat_flag_next  = 1'b0;
            if (above) begin
                // Track the largest sample above threshold
                if (peak_up) begin
                    peak_next     = sample_reg[hrpd_pkg::PEAK_W-1:0];
                    peak_idx_next = count_reg;
                end
                count_next = count_inc;
            end else if (prev_above) begin
                // Falling edge through the threshold
                if (interval_ok) begin
                    beat_flag_next = 1'b1;
                    count_next     = count_reg - peak_idx_reg;
                    thr_next       = thr_sum[hrpd_pkg::THR_W:1];
                end else begin
                    count_next = count_inc;
                end
                peak_next = '0;
            end else begin
                // Quiet: decay toward the floor
                if (thr_reg > hrpd_pkg::THR_W'(min_thr_reg)) begin
                    thr_next = decay_prod[hrpd_pkg::THR_W+hrpd_pkg::DECAY_SHIFT-1:
                                          hrpd_pkg::DECAY_SHIFT];
                end
                count_next = count_inc;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            hrpd_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    state_next = hrpd_pkg::ST_EVAL;
                end
            end
            hrpd_pkg::ST_EVAL: begin
                if (!above && prev_above && interval_ok) begin
                    div_start  = 1'b1;
                    state_next = hrpd_pkg::ST_DIV;
                end else begin
                    state_next = hrpd_pkg::ST_OUT;
                end
            end
            hrpd_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = hrpd_pkg::ST_OUT;
                end
            end
            hrpd_pkg::ST_OUT: begin
                // Wait for the output register to free up
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = hrpd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hrpd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Divider: rate = (60 * sample_rate << 10) / peak_index
    // ------------------------------------------------------------------------
    hrpd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    // ------------------------------------------------------------------------
    // Control and detector state
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= hrpd_pkg::ST_IDLE;
            m_valid_reg  <= 1'b0;
            min_thr_reg  <= hrpd_pkg::MIN_THR_W'(hrpd_pkg::THR_RESET);
            rate_reg     <= hrpd_pkg::RATE_W'(hrpd_pkg::RATE_RESET);
            thr_reg      <= hrpd_pkg::THR_W'(hrpd_pkg::THR_RESET);
            peak_reg     <= '0;
            peak_idx_reg <= '0;
            count_reg    <= '0;
            prev_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            peak_reg     <= peak_next;
            peak_idx_reg <= peak_idx_next;
            count_reg    <= count_next;
            if (state_reg == hrpd_pkg::ST_EVAL) begin
                prev_reg <= sample_reg;
            end
            // The user must send configuration only while idle; the block does not
            // enforce this. A floor write reloads the live threshold.
            if (cfg_xfer && cfg_index == hrpd_pkg::CFG_MIN_THRESHOLD) begin
                min_thr_reg <= cfg_data;
                thr_reg     <= hrpd_pkg::THR_W'(cfg_data);
            end else begin
                thr_reg     <= thr_next;
            end
            if (cfg_xfer && cfg_index == hrpd_pkg::CFG_SAMPLE_RATE) begin
                rate_reg <= cfg_data[hrpd_pkg::RATE_W-1:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            sample_reg <= s_tdata[hrpd_pkg::SAMPLE_WIDTH-1:0];
        end
        above_flag_reg <= above_flag_next;
        beat_flag_reg  <= beat_flag_next;
        if (out_load) begin
            out_above_reg <= above_flag_reg;
            out_beat_reg  <= beat_flag_reg;
            out_rate_reg  <= beat_flag_reg ? div_quot[hrpd_pkg::RATE_OUT_W-1:0] : '0;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = hrpd_pkg::M_TDATA_W'({out_rate_reg, out_above_reg});
    assign m_tuser[0] = out_beat_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // A beat is reported on a sample at or below the threshold
    `HRPD_ASSERT_IMPL(a_beat_not_above, aclk, aresetn, m_tvalid && m_tuser[0], !m_tdata[0])
    // Rate is zero unless a beat is flagged
    `HRPD_ASSERT_IMPL(a_rate_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata[23:1] == '0)
    // Divider finishes only while the sequencer waits on it
    `HRPD_ASSERT_IMPL(a_div_done_state, aclk, aresetn, div_done, state_reg == hrpd_pkg::ST_DIV)
    // An accepted sample is evaluated in the next cycle
    `HRPD_ASSERT_NEXT(a_accept_eval, aclk, aresetn, s_xfer, state_reg == hrpd_pkg::ST_EVAL)

endmodule

// ===== rtl/hrpd_div.sv =====
// ============================================================================
// hrpd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module hrpd_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [hrpd_pkg::DIV_W-1:0]  num,
    input  logic [hrpd_pkg::DIV_W-1:0]  den,
    output logic                        done,
    output logic [hrpd_pkg::DIV_W-1:0]  quot
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [hrpd_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [hrpd_pkg::DIV_W-1:0]        rem_reg, rem_next;
    logic [hrpd_pkg::DIV_W-1:0]        quo_reg, quo_next;
    logic [hrpd_pkg::DIV_W-1:0]        den_reg, den_next;

    logic [hrpd_pkg::DIV_W:0]          rem_sh;
    logic [hrpd_pkg::DIV_W+1:0]        diff;
    logic                              ge;

    always_comb begin
        rem_sh = {rem_reg, quo_reg[hrpd_pkg::DIV_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, den_reg};
        ge     = ~diff[hrpd_pkg::DIV_W+1];

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;

        if (start) begin
            busy_next = 1'b1;
            cnt_next  = hrpd_pkg::DIV_CNT_W'(hrpd_pkg::DIV_W);
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end else if (busy_reg) begin
            rem_next = ge ? diff[hrpd_pkg::DIV_W-1:0] : rem_sh[hrpd_pkg::DIV_W-1:0];
            quo_next = {quo_reg[hrpd_pkg::DIV_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == hrpd_pkg::DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and result registers
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule
